>>> rtl/brks_pkg.sv
`default_nettype none

package brks_pkg;

    // Default depth of the store.
    localparam int MAX_ENTRIES_DEF = 64;

    // Field widths fixed by the interface.
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 32;
    localparam int HANDLE_W = 64;
    localparam int COUNT_W  = 7;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    // One input beat.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [INDEX_W-1:0]  msg_index;
        logic [HANDLE_W-1:0] key_handle;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] result_handle;
        logic                evicted;
        logic [COUNT_W-1:0]  entry_count;
    } result_t;

    // One stored entry.
    typedef struct packed {
        logic [INDEX_W-1:0]  msg_index;
        logic [HANDLE_W-1:0] key_handle;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the accepted beat
        logic add_read;   // read the slot in front of the head
        logic add_write;  // write the new entry and post the add result
        logic scan_start; // rewind the scan pointer
        logic scan_step;  // issue the next scan read
        logic move_start; // begin closing the gap at the matched position
        logic move_step;  // issue the next move read
        logic res_hit;    // post a found result
        logic res_miss;   // post a not-found result
        logic res_del;    // post a delete result and drop one entry
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;        // registered read data matches the key
        logic scan_empty; // every stored entry was read without a match
        logic move_done;  // gap closed, no write pending
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/brks_ctrl.sv
`default_nettype none

module brks_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [brks_pkg::OP_W-1:0] op,
    input  wire brks_pkg::stat_t        stat,
    output brks_pkg::cmd_t              cmd,
    output logic                        busy
);

    import brks_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_MOVE = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [OP_W-1:0]     op_reg;
    logic [OP_W-1:0]     op_next;

    // State and latched operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = op;
                    case (op)
                        OP_ADD:
                        begin
                            cmd.add_read = 1'b1;
                            state_next   = S_ADD;
                        end
                        OP_FIND, OP_DELETE:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            // Unused code: report not found at once.
                            cmd.res_miss = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    if (op_reg == OP_FIND)
                    begin
                        cmd.res_hit = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.move_start = 1'b1;
                        state_next     = S_MOVE;
                    end
                end
                else if (stat.scan_empty)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_MOVE:
            begin
                if (stat.move_done)
                begin
                    cmd.res_del = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.move_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/brks_datapath.sv
`default_nettype none

module brks_datapath #(
    parameter int MAX_ENTRIES = brks_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire brks_pkg::item_t   item,
    input  wire brks_pkg::cmd_t    cmd,
    output brks_pkg::stat_t        stat,
    output brks_pkg::result_t      result,
    output logic                   done
);

    import brks_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW:0]   MAX_W = (CW + 1)'(MAX_ENTRIES);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
    localparam logic [AW-1:0] LAST_A = AW'(MAX_ENTRIES - 1);

    // Map a position (zero is newest) to a physical slot of the ring.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(pos);
        if (s >= MAX_W)
        begin
            s = s - MAX_W;
        end
        return s[AW-1:0];
    endfunction

    // Count as seen on the 7-bit result field.
    function automatic logic [COUNT_W-1:0] count_out(input logic [CW-1:0] c);
        logic [CW+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, c};
        return w[COUNT_W-1:0];
    endfunction

    entry_t              mem [MAX_ENTRIES];
    entry_t              rd_data_reg;

    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    item_t               item_reg;
    logic [CW-1:0]       issue_pos_reg, issue_pos_next;
    logic [CW-1:0]       rd_pos_reg, rd_pos_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [CW-1:0]       mv_pos_reg, mv_pos_next;
    logic                wr_pending_reg, wr_pending_next;
    logic [AW-1:0]       wr_dst_reg, wr_dst_next;
    result_t             result_reg, result_next;
    logic                done_reg, done_next;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    logic [AW-1:0]       head_m1;
    logic [CW-1:0]       mv_src_pos;
    logic                full;
    logic                key_match;

    assign head_m1    = (head_reg == '0) ? LAST_A : head_reg - AW'(1);
    assign mv_src_pos = mv_pos_reg + CW'(1);
    assign full       = (count_reg == MAX_C);

    // Key compare on the registered read data.
    always_comb
    begin
        if (item_reg.op == OP_FIND)
        begin
            key_match = (rd_data_reg.msg_index == item_reg.msg_index);
        end
        else
        begin
            key_match = (rd_data_reg.key_handle == item_reg.key_handle);
        end
    end

    assign stat.hit        = rd_valid_reg && key_match;
    assign stat.scan_empty = !rd_valid_reg && (issue_pos_reg >= count_reg);
    assign stat.move_done  = !wr_pending_reg && (mv_src_pos >= count_reg);

    // Read port, write port and sequencing registers.
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        issue_pos_next  = issue_pos_reg;
        rd_pos_next     = rd_pos_reg;
        rd_valid_next   = 1'b0;
        mv_pos_next     = mv_pos_reg;
        wr_pending_next = 1'b0;
        wr_dst_next     = wr_dst_reg;
        result_next     = result_reg;
        done_next       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = phys(head_reg, issue_pos_reg);
        wr_en           = 1'b0;
        wr_addr         = wr_dst_reg;
        wr_data         = rd_data_reg;

        if (cmd.add_read)
        begin
            rd_en   = 1'b1;
            rd_addr = head_m1;
        end

        // New entry goes in front of the head; a full ring overwrites the oldest.
        if (cmd.add_write)
        begin
            wr_en     = 1'b1;
            wr_addr   = head_m1;
            wr_data.msg_index  = item_reg.msg_index;
            wr_data.key_handle = item_reg.key_handle;
            head_next = head_m1;
            if (!full)
            begin
                count_next = count_reg + CW'(1);
            end
            result_next.status        = STATUS_OK;
            result_next.evicted       = full;
            result_next.result_handle = full ? rd_data_reg.key_handle : '0;
            result_next.entry_count   = count_out(full ? count_reg
                                                       : count_reg + CW'(1));
            done_next = 1'b1;
        end

        if (cmd.scan_start)
        begin
            issue_pos_next = '0;
        end

        // Scan reads go out one per cycle; the compare is made on the registered read data in the following cycle.
        if (cmd.scan_step && (issue_pos_reg < count_reg))
        begin
            rd_en          = 1'b1;
            rd_addr        = phys(head_reg, issue_pos_reg);
            rd_valid_next  = 1'b1;
            rd_pos_next    = issue_pos_reg;
            issue_pos_next = issue_pos_reg + CW'(1);
        end

        if (cmd.move_start)
        begin
            mv_pos_next = rd_pos_reg;
        end

        // Gap closing: read the next older entry, write it one place newer.
        if (cmd.move_step && (mv_src_pos < count_reg))
        begin
            rd_en           = 1'b1;
            rd_addr         = phys(head_reg, mv_src_pos);
            wr_pending_next = 1'b1;
            wr_dst_next     = phys(head_reg, mv_pos_reg);
            mv_pos_next     = mv_src_pos;
        end

        if (wr_pending_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = wr_dst_reg;
            wr_data = rd_data_reg;
        end

        if (cmd.res_hit)
        begin
            result_next.status        = STATUS_OK;
            result_next.evicted       = 1'b0;
            result_next.result_handle = rd_data_reg.key_handle;
            result_next.entry_count   = count_out(count_reg);
            done_next = 1'b1;
        end

        if (cmd.res_miss)
        begin
            result_next.status        = STATUS_NOT_FOUND;
            result_next.evicted       = 1'b0;
            result_next.result_handle = '0;
            result_next.entry_count   = count_out(count_reg);
            done_next = 1'b1;
        end

        if (cmd.res_del)
        begin
            count_next = count_reg - CW'(1);
            result_next.status        = STATUS_OK;
            result_next.evicted       = 1'b0;
            result_next.result_handle = '0;
            result_next.entry_count   = count_out(count_reg - CW'(1));
            done_next = 1'b1;
        end
    end

    // Entry memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Latched beat, result payload and move write address.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
        wr_dst_reg <= wr_dst_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            issue_pos_reg  <= '0;
            rd_pos_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            mv_pos_reg     <= '0;
            wr_pending_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            issue_pos_reg  <= issue_pos_next;
            rd_pos_reg     <= rd_pos_next;
            rd_valid_reg   <= rd_valid_next;
            mv_pos_reg     <= mv_pos_next;
            wr_pending_reg <= wr_pending_next;
            done_reg       <= done_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> rtl/bounded_recent_key_store_top.sv
`default_nettype none

// Ordered store of up to MAX_ENTRIES (message index, key handle) entries, newest
// first, kept as a ring in one memory with one read and one write port. A beat is
// taken when start is high and busy is low; its result appears on result for one
// cycle with done high and must be taken then, since the block cannot be held off.
// An add reads the slot in front of the head, then writes the new entry there. A
// find scans from the newest entry until a match or until every entry was read; a
// delete scans the same way and, on a match, closes the gap one entry per cycle,
// moving each older entry one place newer. Unused op codes answer not found at
// once. The single memory read port sets the pace, one entry per cycle. busy is
// low again in the cycle that shows the result, so the next beat can be taken at
// the same edge as that result.
module bounded_recent_key_store_top #(
    parameter int MAX_ENTRIES = brks_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire brks_pkg::item_t   item,
    output logic                   busy,
    output logic                   done,
    output brks_pkg::result_t      result
);

    import brks_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    brks_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Ring memory, pointers and result register.
    brks_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_bounded_recent_key_store_top.sv
`default_nettype none

module tb_bounded_recent_key_store_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brks_pkg::*;

    localparam int DEPTH        = MAX_ENTRIES_DEF;
    localparam int RANDOM_BEATS = 1330;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PRINT_LIMIT  = 40;

    // The fourth op code has no name in the package; the store must ignore it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    done;
    result_t result;

    bounded_recent_key_store_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Shadow copy of the store, newest entry at position zero.
    logic [INDEX_W-1:0]  shadow_index  [DEPTH];
    logic [HANDLE_W-1:0] shadow_handle [DEPTH];
    int                  shadow_count;

    item_t   pending_beats[$];
    result_t expected_results[$];

    logic beat_taken;
    logic burst_mode;
    int   gap_left;
    int   stall_cycles;
    int   mismatch_count;

    int n_adds, n_evictions, n_find_hits, n_find_misses;
    int n_del_hits, n_del_misses, n_unused, peak_count;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One line per mismatch, with the printout capped for long failing runs.
    task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] want,
                                   input logic [HANDLE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
    endtask

    // Applies one operation to the shadow store and returns the result it must give.
    function automatic result_t predict_store_op(input item_t beat);
        result_t r;
        int      pos;
        int      hit;
        r.status        = STATUS_NOT_FOUND;
        r.result_handle = '0;
        r.evicted       = 1'b0;
        hit             = -1;
        case (beat.op)
            OP_ADD:
            begin
                n_adds++;
                if (shadow_count == DEPTH)
                begin
                    r.result_handle = shadow_handle[DEPTH-1];
                    r.evicted       = 1'b1;
                    n_evictions++;
                end
                else
                    shadow_count++;
                for (pos = shadow_count - 1; pos > 0; pos--)
                begin
                    shadow_index[pos]  = shadow_index[pos-1];
                    shadow_handle[pos] = shadow_handle[pos-1];
                end
                shadow_index[0]  = beat.msg_index;
                shadow_handle[0] = beat.key_handle;
                r.status         = STATUS_OK;
            end
            OP_FIND:
            begin
                for (pos = 0; pos < shadow_count && hit < 0; pos++)
                    if (shadow_index[pos] == beat.msg_index)
                        hit = pos;
                if (hit >= 0)
                begin
                    r.status        = STATUS_OK;
                    r.result_handle = shadow_handle[hit];
                    n_find_hits++;
                end
                else
                    n_find_misses++;
            end
            OP_DELETE:
            begin
                for (pos = 0; pos < shadow_count && hit < 0; pos++)
                    if (shadow_handle[pos] == beat.key_handle)
                        hit = pos;
                if (hit >= 0)
                begin
                    // Close the gap left by the newest matching entry.
                    for (pos = hit; pos < shadow_count - 1; pos++)
                    begin
                        shadow_index[pos]  = shadow_index[pos+1];
                        shadow_handle[pos] = shadow_handle[pos+1];
                    end
                    shadow_count--;
                    r.status = STATUS_OK;
                    n_del_hits++;
                end
                else
                    n_del_misses++;
            end
            default:
                n_unused++;
        endcase
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        r.entry_count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // Gap before the next beat: mostly short, now and then long, none in a burst.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic logic [INDEX_W-1:0] random_index();
        if ($urandom_range(0, 99) < 35)
            return INDEX_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    function automatic logic [HANDLE_W-1:0] random_handle();
        if ($urandom_range(0, 99) < 20)
            return HANDLE_W'($urandom_range(0, 15));
        return {$urandom, $urandom};
    endfunction

    task automatic queue_beat(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                              input logic [HANDLE_W-1:0] hdl);
        item_t b;
        b.op         = op;
        b.msg_index  = idx;
        b.key_handle = hdl;
        pending_beats.push_back(b);
    endtask

    // Random beat whose operation mix follows the phase; finds and deletes
    // mostly aim at entries that are stored right now.
    task automatic queue_random_beat(input phase_t ph);
        logic [OP_W-1:0]     op;
        logic [INDEX_W-1:0]  idx;
        logic [HANDLE_W-1:0] hdl;
        int                  roll;
        int                  add_lim;
        int                  find_lim;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
            begin
                add_lim  = 72;
                find_lim = 87;
            end
            PH_DRAIN:
            begin
                add_lim  = 20;
                find_lim = 42;
            end
            default:
            begin
                add_lim  = 40;
                find_lim = 70;
            end
        endcase
        if (roll < add_lim)
            op = OP_ADD;
        else if (roll < find_lim)
            op = OP_FIND;
        else if (roll < 97)
            op = OP_DELETE;
        else
            op = OP_UNUSED;
        idx = random_index();
        hdl = random_handle();
        if (shadow_count > 0)
        begin
            roll = $urandom_range(0, 99);
            if (op == OP_FIND && roll < 65)
                idx = shadow_index[$urandom_range(0, shadow_count - 1)];
            else if (op == OP_DELETE && roll < 65)
                hdl = shadow_handle[$urandom_range(0, shadow_count - 1)];
            else if (op == OP_ADD && roll < 12)
                hdl = shadow_handle[$urandom_range(0, shadow_count - 1)];
        end
        queue_beat(op, idx, hdl);
    endtask

    // Driver: holds a beat until it is taken, then idles or presents the next one.
    always @(negedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else if (start && !beat_taken)
        begin
        end
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_beats.size() != 0)
        begin
            item     <= pending_beats.pop_front();
            start    <= 1'b1;
            gap_left <= pick_gap();
        end
        else
            start <= 1'b0;
    end

    // Monitor: checks each result beat, then predicts for a beat taken at this edge.
    always @(posedge clk)
    begin
        result_t want;
        logic    accept;
        accept = (rst_n === 1'b1) && (start === 1'b1) && (busy === 1'b0);
        beat_taken <= accept;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", '0, result.result_handle);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", HANDLE_W'(want.status),
                                        HANDLE_W'(result.status));
                    if (result.result_handle !== want.result_handle)
                        report_mismatch("result_handle", want.result_handle,
                                        result.result_handle);
                    if (result.evicted !== want.evicted)
                        report_mismatch("evicted", HANDLE_W'(want.evicted),
                                        HANDLE_W'(result.evicted));
                    if (result.entry_count !== want.entry_count)
                        report_mismatch("entry_count", HANDLE_W'(want.entry_count),
                                        HANDLE_W'(result.entry_count));
                end
            end
            if (accept)
                expected_results.push_back(predict_store_op(item));

            // Watchdog on cycles in which no beat moves in either direction.
            if (accept || done === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         stall_cycles, expected_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        phase_t ph;
        int     left_in_phase;
        int     issued;
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        beat_taken     = 1'b0;
        burst_mode     = 1'b0;
        shadow_count   = 0;
        stall_cycles   = 0;
        mismatch_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty store: misses and the unused op code.
        queue_beat(OP_FIND,   '0, '0);
        queue_beat(OP_DELETE, '0, '0);
        queue_beat(OP_UNUSED, '1, '1);
        // Field extremes, hits at both positions and a miss.
        queue_beat(OP_ADD,  '0, '0);
        queue_beat(OP_ADD,  '1, '1);
        queue_beat(OP_FIND, '1, '0);
        queue_beat(OP_FIND, '0, '1);
        queue_beat(OP_FIND, 32'h0001_2345, '0);
        // Duplicate handle and duplicate index: only the newest match counts.
        queue_beat(OP_ADD,    32'd7, '1);
        queue_beat(OP_ADD,    32'd7, 64'hA5A5_A5A5_A5A5_A5A5);
        queue_beat(OP_FIND,   32'd7, '0);
        queue_beat(OP_DELETE, '0, '1);
        queue_beat(OP_FIND,   32'd7, '0);
        queue_beat(OP_FIND,   '1, '0);
        queue_beat(OP_DELETE, '0, '1);
        queue_beat(OP_DELETE, '0, '1);
        // Delete the oldest, ignore an unused op with entries, empty the store.
        queue_beat(OP_DELETE, '0, '0);
        queue_beat(OP_UNUSED, 32'h5A5A_5A5A, 64'h5555_5555_5555_5555);
        queue_beat(OP_DELETE, '1, 64'hA5A5_A5A5_A5A5_A5A5);
        queue_beat(OP_ADD,    32'h5A5A_5A5A, 64'h5555_5555_5555_5555);
        queue_beat(OP_DELETE, '0, 64'h5555_5555_5555_5555);

        // Random phases; the first one fills the store well past full.
        ph            = PH_FILL;
        left_in_phase = 180;
        issued        = 0;
        while (issued < RANDOM_BEATS)
        begin
            while (pending_beats.size() != 0)
            begin
                @(posedge clk);
                #1;
            end
            queue_random_beat(ph);
            issued++;
            left_in_phase--;
            if (left_in_phase == 0)
            begin
                ph            = phase_t'($urandom_range(0, 2));
                left_in_phase = $urandom_range(60, 200);
                burst_mode    = ($urandom_range(0, 3) == 0);
            end
        end

        // Let everything drain, then watch a while for stray result beats.
        while (pending_beats.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("adds %0d (evicting %0d), finds %0d hit / %0d missed, peak %0d entries",
                 n_adds, n_evictions, n_find_hits, n_find_misses, peak_count);
        $display("deletes %0d hit / %0d missed, unused op %0d, mismatches %0d",
                 n_del_hits, n_del_misses, n_unused, mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
